@@ rtl/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the shelf atlas allocator.
// ----------------------------------------------------------------------------
package sal_pkg;

    // field widths
    localparam int CFG_W   = 13;   // config data, widest register
    localparam int TEX_W   = 12;   // request width and height
    localparam int X_W     = 12;   // placement x
    localparam int Y_W     = 13;   // placement y
    localparam int FILL_W  = 13;   // shelf fill point and base row
    localparam int NFY_W   = 14;   // next free row
    localparam int PPU_W   = 9;    // shelf class granularity
    localparam int MUL_W   = 9;    // shelf class plus one
    localparam int PROD_W  = 18;   // granularity times class plus one
    localparam int YSUM_W  = 19;   // next free row plus shelf height
    localparam int STAT_W  = 2;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = TEX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = PPU_W;

    // register indexes
    localparam logic REG_ATLAS_SIZE = 1'b0;
    localparam logic REG_PIX_UNIT   = 1'b1;

    // reset values
    localparam logic [CFG_W-1:0] ATLAS_SIZE_RST = 13'd1024;
    localparam logic [PPU_W-1:0] PIX_UNIT_RST   = 9'd16;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_CLASS = 2'd1;
    localparam logic [STAT_W-1:0] ST_WIDE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CLS,
        S_LOOK
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture request, set up the divider
        logic div_step;   // one restoring division step
        logic cls_eval;   // class range check and shelf height product
        logic commit;     // decide placement, update state, drive result
    } t_dp_cmd;

endpackage

@@ rtl/sal_ram.sv @@
// ----------------------------------------------------------------------------
// sal_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module sal_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sal_ctrl.sv @@
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer: request capture, division steps, class check, commit.
// ----------------------------------------------------------------------------
module sal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_valid,
    output sal_pkg::t_dp_cmd o_cmd
);
    import sal_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_valid;
    t_dp_cmd             w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= w_cmd.commit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_CLS;
                end
            end
            S_CLS: begin
                w_cmd.cls_eval = 1'b1;
                n_state        = S_LOOK;
            end
            S_LOOK: begin
                w_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = w_cmd;

endmodule

@@ rtl/sal_dpath.sv @@
// ----------------------------------------------------------------------------
// sal_dpath
// Config registers, class divider, shelf table and placement arithmetic.
// ----------------------------------------------------------------------------
module sal_dpath #(
    parameter int SHELF_CLASSES = 16,
    parameter int MAX_ATLAS     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sal_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [sal_pkg::TEX_W-1:0]     i_tex_width,
    input  logic [sal_pkg::TEX_W-1:0]     i_tex_height,
    input  sal_pkg::t_dp_cmd              i_cmd,
    output logic [sal_pkg::X_W-1:0]       o_place_x,
    output logic [sal_pkg::Y_W-1:0]       o_place_y,
    output logic [sal_pkg::STAT_W-1:0]    o_status
);
    import sal_pkg::*;

    localparam int CW     = (SHELF_CLASSES > 1) ? $clog2(SHELF_CLASSES) : 1;
    localparam int ENTRY_W = 2 * FILL_W;

    // config
    logic [CFG_W-1:0]   r_atlas_size;
    logic [PPU_W-1:0]   r_pix_unit;
    logic [PPU_W-1:0]   w_ppu;
    logic [CFG_W-1:0]   w_size;

    // request and divider
    logic [TEX_W-1:0]   r_w;
    logic [TEX_W-1:0]   r_quo;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W:0]     w_trial;
    logic               w_ge;

    // class stage
    logic [PROD_W-1:0]  r_prod;
    logic               r_cls_err;
    logic [MUL_W-1:0]   w_cls_p1;
    logic [CW-1:0]      w_idx;

    // shelf state
    logic [SHELF_CLASSES-1:0] r_open;
    logic [NFY_W-1:0]   r_nfy;
    logic [ENTRY_W-1:0] w_rdata, w_wdata;
    logic               w_we;

    // placement
    logic [FILL_W-1:0]  w_pw, w_fill_old, w_base_old, w_fill_use, w_base_use;
    logic [FILL_W:0]    w_fill_sum;
    logic [PROD_W-1:0]  w_shelf_h;
    logic [YSUM_W-1:0]  w_y_sum;
    logic               w_fresh, w_wide, w_full;
    logic [STAT_W-1:0]  w_status;

    // outputs
    logic [X_W-1:0]     r_place_x;
    logic [Y_W-1:0]     r_place_y;
    logic [STAT_W-1:0]  r_status;

    assign w_ppu  = (r_pix_unit == '0) ? PPU_W'(1) : r_pix_unit;
    assign w_size = ({2'b00, r_atlas_size} > 15'(MAX_ATLAS)) ? CFG_W'(MAX_ATLAS)
                                                            : r_atlas_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_size <= ATLAS_SIZE_RST;
            r_pix_unit   <= PIX_UNIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ATLAS_SIZE: r_atlas_size <= i_cfg_data;
                REG_PIX_UNIT:   r_pix_unit   <= i_cfg_data[PPU_W-1:0];
                default:        r_atlas_size <= r_atlas_size;
            endcase
        end
    end

    // restoring division, one quotient bit a step
    assign w_trial = {r_rem, r_quo[TEX_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_ppu});

    assign w_cls_p1 = MUL_W'(r_quo[7:0]) + MUL_W'(1);
    assign w_idx    = r_quo[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w   <= i_tex_width;
            r_quo <= (i_tex_height == '0) ? '0 : i_tex_height - TEX_W'(1);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? REM_W'(w_trial - {1'b0, w_ppu}) : w_trial[REM_W-1:0];
            r_quo <= {r_quo[TEX_W-2:0], w_ge};
        end
        if (i_cmd.cls_eval) begin
            r_prod    <= PROD_W'(w_ppu) * PROD_W'(w_cls_p1);
            r_cls_err <= ({1'b0, r_quo} >= (TEX_W+1)'(SHELF_CLASSES));
        end
    end

    // fill point in the upper half, base row in the lower half
    sal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SHELF_CLASSES)
    ) u_shelf_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign w_fill_old = w_rdata[ENTRY_W-1:FILL_W];
    assign w_base_old = w_rdata[FILL_W-1:0];
    assign w_pw       = FILL_W'(r_w) + FILL_W'(2);
    assign w_shelf_h  = r_prod + PROD_W'(2);
    assign w_fill_sum = {1'b0, w_fill_old} + {1'b0, w_pw};
    assign w_fresh    = !r_open[w_idx] || (w_fill_sum >= (FILL_W+1)'(w_size));
    assign w_wide     = (w_pw >= w_size);
    assign w_y_sum    = YSUM_W'(r_nfy) + YSUM_W'(w_shelf_h);
    assign w_full     = (w_y_sum > YSUM_W'(w_size));

    always_comb begin
        if (r_cls_err) begin
            w_status = ST_CLASS;
        end else if (w_fresh && w_wide) begin
            w_status = ST_WIDE;
        end else if (w_fresh && w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_fill_use = w_fresh ? '0 : w_fill_old;
    assign w_base_use = w_fresh ? r_nfy[FILL_W-1:0] : w_base_old;
    assign w_wdata    = {FILL_W'(w_fill_use + w_pw), w_base_use};
    assign w_we       = i_cmd.commit && (w_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            r_nfy  <= '0;
        end else if (w_we && w_fresh) begin
            r_open[w_idx] <= 1'b1;
            r_nfy         <= NFY_W'(w_y_sum + YSUM_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
            if (w_status == ST_OK) begin
                r_place_x <= X_W'(w_fill_use + FILL_W'(1));
                r_place_y <= Y_W'(w_base_use + FILL_W'(1));
            end else begin
                r_place_x <= '0;
                r_place_y <= '0;
            end
        end
    end

    assign o_place_x = r_place_x;
    assign o_place_y = r_place_y;
    assign o_status  = r_status;

endmodule

@@ rtl/shelf_atlas_allocator.sv @@
// ----------------------------------------------------------------------------
// shelf_atlas_allocator
// Shelf packer for a square texture atlas: one placement word per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ------------------------------
//  request   in         start & !busy        i_tex_width, i_tex_height
//  result    out        o_valid (one cycle)  o_place_x, o_place_y, o_status
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  o_valid is registered from the commit: S_DIV runs the twelve steps of the
//  restoring divider that finds the shelf class, S_CLS does the class check
//  and shelf height multiply, S_LOOK does the shelf table read and commit;
//  busy is low in the strobe cycle, so the next request is taken at the
//  same edge as the result word, and no new request is taken while one is
//  in flight
//  synchronous active low reset closes all shelves and sets the next free
//  row to zero; config returns to atlas 1024, granularity 16
//  the result cannot be held off; nothing in the block stalls
//
module shelf_atlas_allocator #(
    parameter int SHELF_CLASSES = 16,
    parameter int MAX_ATLAS     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic [sal_pkg::TEX_W-1:0]     i_tex_width,
    input  logic [sal_pkg::TEX_W-1:0]     i_tex_height,
    // result
    output logic                          o_valid,
    output logic [sal_pkg::X_W-1:0]       o_place_x,
    output logic [sal_pkg::Y_W-1:0]       o_place_y,
    output logic [sal_pkg::STAT_W-1:0]    o_status,
    // config write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sal_pkg::CFG_W-1:0]     i_cfg_data
);
    import sal_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer: request capture, divide, class check, commit
    sal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // config, divider, shelf table and result registers
    sal_dpath #(
        .SHELF_CLASSES (SHELF_CLASSES),
        .MAX_ATLAS     (MAX_ATLAS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tex_width  (i_tex_width),
        .i_tex_height (i_tex_height),
        .i_cmd        (w_cmd),
        .o_place_x    (o_place_x),
        .o_place_y    (o_place_y),
        .o_status     (o_status)
    );

    // an accepted request makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // the result strobe is a single cycle pulse
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // every commit shows a result on the next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("commit without result strobe");

    // a failed request places nothing
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_place_x == '0 && o_place_y == '0))
        else $error("error result with nonzero placement");

endmodule

@@ tb/shelf_atlas_allocator_test.sv @@
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_test
// Self-checking bench for the shelf atlas allocator. A scoreboard keeps its
// own copy of the shelf table, the next free row and the two config
// registers, predicts the placement word for every accepted request, and
// compares it field by field with each result strobe. A short directed list
// covers the boundaries. Config phases then run constrained random traffic,
// with idle bursts on the request side, over the zero, minimum, maximum and
// clamped register values.
// ----------------------------------------------------------------------------
module shelf_atlas_allocator_test;
    import sal_pkg::*;

    localparam int SHELF_CLASSES  = 16;
    localparam int MAX_ATLAS      = 4096;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 20;    // longer than a request takes to come back
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result taken
    localparam int TEX_MAX        = 4095;

    // one expected result word
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [STAT_W-1:0] st;
    } placement_t;

    // ------------------------------------------------------------------------
    // scoreboard: shelf table shadow and the queue of pending placements
    // ------------------------------------------------------------------------
    class shelf_scoreboard;
        logic [CFG_W-1:0]  atlas_side;
        logic [PPU_W-1:0]  pix_unit;
        bit                shelf_open [SHELF_CLASSES];
        logic [FILL_W-1:0] shelf_fill [SHELF_CLASSES];
        logic [FILL_W-1:0] shelf_base [SHELF_CLASSES];
        logic [NFY_W-1:0]  next_row;
        placement_t        placements [$];
        int                errors;

        function new();
            atlas_side = ATLAS_SIZE_RST;
            pix_unit   = PIX_UNIT_RST;
            next_row   = '0;
            errors     = 0;
            for (int i = 0; i < SHELF_CLASSES; i++) begin
                shelf_open[i] = 1'b0;
                shelf_fill[i] = '0;
                shelf_base[i] = '0;
            end
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_ATLAS_SIZE) begin
                atlas_side = data;
            end else begin
                pix_unit = data[PPU_W-1:0];
            end
        endfunction

        // works out the placement for one accepted request and updates the table
        function void note_request(logic [TEX_W-1:0] w, logic [TEX_W-1:0] h);
            int unsigned ppu, side, pw, cls, shelf_h, fill;
            bit          fresh;
            placement_t  p;
            ppu  = (pix_unit == 0) ? 1 : pix_unit;
            side = (atlas_side > MAX_ATLAS) ? MAX_ATLAS : atlas_side;
            pw   = w + 2;
            cls  = (h == 0) ? 0 : (h - 1) / ppu;
            p    = '0;
            if (cls >= SHELF_CLASSES) begin
                p.st = ST_CLASS;
            end else begin
                shelf_h = ppu * cls + ppu + 2;
                fresh   = !shelf_open[cls] || (shelf_fill[cls] + pw >= side);
                if (fresh && pw >= side) begin
                    p.st = ST_WIDE;
                end else if (fresh && next_row + shelf_h > side) begin
                    p.st = ST_FULL;
                end else begin
                    if (fresh) begin
                        shelf_open[cls] = 1'b1;
                        shelf_base[cls] = FILL_W'(next_row);
                        shelf_fill[cls] = '0;
                        next_row        = NFY_W'(next_row + shelf_h + 1);
                    end
                    fill            = shelf_fill[cls];
                    shelf_fill[cls] = FILL_W'(fill + pw);
                    p.x             = X_W'(fill + 1);
                    p.y             = Y_W'(shelf_base[cls] + 1);
                    p.st            = ST_OK;
                end
            end
            placements.push_back(p);
        endfunction

        function void check_result(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                   logic [STAT_W-1:0] st);
            placement_t want;
            if (placements.size() == 0) begin
                $display("%0t: result x=%0d y=%0d status=%0d with no request pending",
                         $time, x, y, st);
                errors++;
                return;
            end
            want = placements.pop_front();
            if (st !== want.st) begin
                $display("%0t: status expected %0d, got %0d", $time, want.st, st);
                errors++;
            end
            if (x !== want.x) begin
                $display("%0t: place_x expected %0d, got %0d", $time, want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $display("%0t: place_y expected %0d, got %0d", $time, want.y, y);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [TEX_W-1:0]  i_tex_width  = '0;
    logic [TEX_W-1:0]  i_tex_height = '0;
    logic              o_valid;
    logic [X_W-1:0]    o_place_x;
    logic [Y_W-1:0]    o_place_y;
    logic [STAT_W-1:0] o_status;
    logic              i_cfg_we     = 1'b0;
    logic              i_cfg_idx    = REG_ATLAS_SIZE;
    logic [CFG_W-1:0]  i_cfg_data   = '0;

    shelf_scoreboard sb = new();
    int              stall_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    shelf_atlas_allocator #(
        .SHELF_CLASSES (SHELF_CLASSES),
        .MAX_ATLAS     (MAX_ATLAS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_tex_width  (i_tex_width),
        .i_tex_height (i_tex_height),
        .o_valid      (o_valid),
        .o_place_x    (o_place_x),
        .o_place_y    (o_place_y),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // result side: every strobe is a word that must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_place_x, o_place_y, o_status);
        end
    end

    // watchdog: restart on any request or result word taken
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // hold start with the word until the block takes it; start stays high so
    // a following word can go out back to back
    task automatic send_request(input logic [TEX_W-1:0] w, input logic [TEX_W-1:0] h);
        start        <= 1'b1;
        i_tex_width  <= w;
        i_tex_height <= h;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(w, h);
    endtask

    // idle burst, either right after the accept (lands while busy) or after
    // the result comes back (lands while the block is idle)
    task automatic idle_burst();
        start        <= 1'b0;
        i_tex_width  <= TEX_W'($urandom);
        i_tex_height <= TEX_W'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            do @(posedge i_clk); while (busy !== 1'b0);
        end
        repeat ($urandom_range(1, 5)) @(posedge i_clk);
    endtask

    // stop requesting and let every predicted word come back
    task automatic drain();
        start <= 1'b0;
        while (sb.placements.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // boundaries under the reset config (atlas 1024, granularity 16)
    task automatic run_directed();
        send_request(12'd0, 12'd0);         // zero size, zero height is class 0
        send_request(12'd4095, 12'd4095);   // all ones, class far beyond table
        send_request(12'd1022, 12'd16);     // padded width equals atlas: too wide
        send_request(12'd1021, 12'd1);      // shelf overflow, widest that fits
        send_request(12'd3, 12'd16);        // class 0 top, full shelf again
        send_request(12'd3, 12'd17);        // first height of class 1
        send_request(12'd0, 12'd257);       // first height past the last class
        send_request(12'd4095, 12'd256);    // last class, too wide
        if ($urandom_range(0, 1) == 1) idle_burst();
        send_request(12'd5, 12'd2);         // lands on the open class 0 shelf
        // top height of every class; the taller ones run out of rows
        for (int k = 0; k < SHELF_CLASSES; k++) begin
            send_request(TEX_W'(k * 60 + 10), TEX_W'(16 * k + 16));
            if ($urandom_range(0, 3) == 0) idle_burst();
        end
    endtask

    // one config setting, then random words shaped to that setting
    task automatic run_phase(input logic [CFG_W-1:0] side_data,
                             input logic [CFG_W-1:0] unit_data,
                             input int count, input bit quiet);
        int unsigned      side, unit, wmax, hmax, pick;
        int               edge_w;
        logic [TEX_W-1:0] w, h;
        drain();
        write_reg(REG_ATLAS_SIZE, side_data);
        write_reg(REG_PIX_UNIT, unit_data);
        i_cfg_we <= 1'b0;
        side = (side_data > MAX_ATLAS) ? MAX_ATLAS : side_data;
        unit = (unit_data[PPU_W-1:0] == 0) ? 1 : unit_data[PPU_W-1:0];
        wmax = (side / 16 < 16) ? 16 : side / 16;
        // mostly legal classes, a slice just past the table
        hmax = unit * SHELF_CLASSES + unit / 2;
        if (hmax > TEX_MAX) hmax = TEX_MAX;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise over the full field range
                w = TEX_W'($urandom_range(0, TEX_MAX));
                h = TEX_W'($urandom_range(0, TEX_MAX));
            end else if (pick < 14) begin
                // padded width right around the atlas side
                edge_w = int'(side) - 2 - int'($urandom_range(0, 3)) + int'($urandom_range(0, 2));
                if (edge_w < 0) edge_w = 0;
                if (edge_w > TEX_MAX) edge_w = TEX_MAX;
                w = TEX_W'(edge_w);
                h = TEX_W'($urandom_range(0, hmax));
            end else begin
                w = TEX_W'($urandom_range(0, wmax));
                h = TEX_W'($urandom_range(0, hmax));
            end
            send_request(w, h);
            // idle in alternating stretches of 40 words, none when quiet
            if (!quiet && (i / 40) % 2 == 0 && $urandom_range(0, 3) == 0) begin
                idle_burst();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // register sweep: zero atlas, granularity zero, clamped atlas, masked
        // granularity write, widest granularity; rows only ever grow, so the
        // small atlas settings go first
        run_phase(13'd0,    13'd16,    40,  1'b0);
        run_phase(13'd1,    13'd0,     40,  1'b0);
        run_phase(13'd1024, 13'd8,     80,  1'b0);
        run_phase(13'd2048, 13'd1,     300, 1'b0);
        run_phase(13'd3000, 13'h1E04,  280, 1'b0);
        run_phase(13'd8191, 13'd256,   200, 1'b0);
        run_phase(13'd4096, 13'd511,   150, 1'b0);
        run_phase(13'd4097, 13'd2,     300, 1'b0);
        // last stretch back to back with no idling
        run_phase(13'd4096, 13'd3,     340, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sal_pkg.sv
rtl/sal_ram.sv
rtl/sal_ctrl.sv
rtl/sal_dpath.sv
rtl/shelf_atlas_allocator.sv
tb/shelf_atlas_allocator_test.sv
